// File: hdl/dspm_pkg.sv
// dspm_pkg: shared types, codes and helpers for the dot-star pattern matcher
// no dependencies; used by the channel interfaces, the cell and the top level
package dspm_pkg;

  // default pattern capacity in bytes
  localparam int DSPM_MAX_PATTERN = 32;

  // special pattern bytes
  localparam logic [7:0] SYM_ANY  = 8'd46;
  localparam logic [7:0] SYM_STAR = 8'd42;

  typedef logic [1:0] opcode_raw_t;
  typedef logic [7:0] symbol_t;

  // request opcodes; the fourth code means nothing and leaves state alone
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LATE = 2'd2
  } status_t;

  // control sequencer
  typedef enum logic {
    S_IDLE = 1'b0,
    S_PROP = 1'b1
  } state_t;

  // step commands broadcast to every cell of the chain
  typedef struct packed {
    logic    start;
    logic    text;
    logic    prop;
    symbol_t symbol;
  } cell_ctrl_t;

  // pattern byte accepts text byte
  function automatic logic sym_hits(input symbol_t pat, input symbol_t c);
    sym_hits = (pat == SYM_ANY) || (pat == c);
  endfunction

endpackage

// File: hdl/dspm_if.sv
// dspm_if: valid/ready channel interfaces for requests and results
// depends on dspm_pkg

// request channel: opcode and symbol
interface dspm_in_if
  import dspm_pkg::*;
  ();
  logic        valid;
  logic        ready;
  opcode_raw_t opcode;
  symbol_t     symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

// result channel: match flag and status
interface dspm_out_if
  import dspm_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] status;

  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

// File: hdl/dspm_cell.sv
// dspm_cell: one pattern position of the matcher chain; holds its pattern byte
// and its dynamic-programming column flag. depends on dspm_pkg
module dspm_cell
  import dspm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl_i,
  input  logic       we_i,        // pattern byte lands in this cell
  input  logic       active_i,    // cell lies within the loaded pattern
  input  logic       has_prev_i,  // a pattern element precedes this cell
  input  logic       flag_m1_i,   // column flag of left neighbor
  input  logic       flag_m2_i,   // column flag two to the left
  input  symbol_t    prev_pat_i,  // pattern byte of left neighbor
  output logic       flag_o,
  output symbol_t    pat_o,
  output logic       grow_o       // closure step would still set this flag
);

  logic    flag_r, flag_nxt;
  symbol_t pat_r, pat_nxt;
  logic    is_star;
  logic    star_ok;

  assign is_star = (pat_r == SYM_STAR);
  assign star_ok = active_i && is_star && has_prev_i;

  // next column flag
  always_comb begin
    flag_nxt = flag_r;
    pat_nxt  = pat_r;
    if (ctrl_i.start) begin
      flag_nxt = 1'b0;
    end else if (we_i) begin
      pat_nxt  = ctrl_i.symbol;
      // empty text matches only when the new star cancels its element
      flag_nxt = (ctrl_i.symbol == SYM_STAR) && has_prev_i && flag_m2_i;
    end else if (ctrl_i.text) begin
      if (!active_i) begin
        flag_nxt = 1'b0;
      end else if (is_star) begin
        flag_nxt = has_prev_i && flag_r && sym_hits(prev_pat_i, ctrl_i.symbol);
      end else begin
        flag_nxt = flag_m1_i && sym_hits(pat_r, ctrl_i.symbol);
      end
    end else if (ctrl_i.prop) begin
      // zero repeats: inherit the flag from before the element
      if (star_ok) begin
        flag_nxt = flag_r || flag_m2_i;
      end
    end
  end

  // flag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  // pattern byte
  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  assign flag_o = flag_r;
  assign pat_o  = pat_r;
  assign grow_o = star_ok && flag_m2_i && !flag_r;

endmodule

// File: hdl/dot_star_pattern_matcher.sv
// dot_star_pattern_matcher: top level with request sequencer, result register
// and the chain of pattern cells. depends on dspm_pkg, dspm_if, dspm_cell
//
// Usage: requests arrive on in_ch (valid/ready). Opcode start clears the
// pattern, opcode pattern appends a pattern byte ('.' any, '*' repeat),
// opcode text consumes one text byte. Every request yields one result on
// out_ch: matched (text so far matches the whole pattern) and status
// (ok, pattern full, pattern byte after text).
// Start, pattern and unused-opcode requests give their result in the cycle
// after acceptance. A text byte updates all cells in parallel, then the
// sequencer steps the closure through chained star elements until no flag
// grows, and a final check registers the result.
// One request is in flight at a time; the next one is taken once its
// result sits in the output register and is being or has been taken.
// Reset empties the pattern, sets the empty-text match and clears the
// output register. While the receiver stalls the result holds in the
// output register and in_ch.ready stays low.
module dot_star_pattern_matcher
  import dspm_pkg::*;
#(
  parameter int MAX_PATTERN = DSPM_MAX_PATTERN
)(
  input  logic          clk,
  input  logic          rst_n,
  dspm_in_if.sink       in_ch,
  dspm_out_if.source    out_ch
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  state_t         state_r, state_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           text_started_r, text_started_nxt;
  logic           col0_r, col0_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           matched_r, matched_nxt;
  status_t        status_r, status_nxt;

  logic           accept;
  logic           load_ok;
  cell_ctrl_t     ctrl;
  logic [MAX_PATTERN:0]   cols;
  logic [MAX_PATTERN:1]   grows;
  symbol_t        pats [MAX_PATTERN:1];
  opcode_raw_t    op;

  assign op     = in_ch.opcode;
  assign accept = in_ch.valid && in_ch.ready;

  // take a request only when idle and the output register frees up
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  // sequencer, request decode and result selection
  always_comb begin
    state_nxt        = state_r;
    len_nxt          = len_r;
    text_started_nxt = text_started_r;
    col0_nxt         = col0_r;
    matched_nxt      = matched_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    load_ok          = 1'b0;
    ctrl             = '0;
    ctrl.symbol      = in_ch.symbol;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_START: begin
              ctrl.start       = 1'b1;
              len_nxt          = '0;
              text_started_nxt = 1'b0;
              col0_nxt         = 1'b1;
              matched_nxt      = 1'b1;
              status_nxt       = ST_OK;
              out_valid_nxt    = 1'b1;
            end
            OP_PATTERN: begin
              out_valid_nxt = 1'b1;
              matched_nxt   = cols[len_r];
              if (text_started_r) begin
                status_nxt = ST_LATE;
              end else if (len_r == LW'(MAX_PATTERN)) begin
                status_nxt = ST_FULL;
              end else begin
                load_ok     = 1'b1;
                len_nxt     = len_r + 1'b1;
                status_nxt  = ST_OK;
                matched_nxt = (in_ch.symbol == SYM_STAR) && (len_r != '0) &&
                              cols[len_r - 1'b1];
              end
            end
            OP_TEXT: begin
              ctrl.text        = 1'b1;
              text_started_nxt = 1'b1;
              col0_nxt         = 1'b0;
              state_nxt        = S_PROP;
            end
            default: begin
              matched_nxt   = cols[len_r];
              status_nxt    = ST_OK;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PROP: begin
        // star closure until no flag changes, then report
        if (|grows) begin
          ctrl.prop = 1'b1;
        end else begin
          matched_nxt   = cols[len_r];
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      len_r          <= '0;
      text_started_r <= 1'b0;
      col0_r         <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      len_r          <= len_nxt;
      text_started_r <= text_started_nxt;
      col0_r         <= col0_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
    status_r  <= status_nxt;
  end

  assign cols[0] = col0_r;

  // chain of cells, one per pattern position
  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
    logic    flag_m2;
    symbol_t prev_pat;
    if (k == 1) begin : g_first
      assign flag_m2  = 1'b0;
      assign prev_pat = '0;
    end else begin : g_rest
      assign flag_m2  = cols[k-2];
      assign prev_pat = pats[k-1];
    end
    dspm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .we_i       (load_ok && (len_r == LW'(k - 1))),
      .active_i   (LW'(k) <= len_r),
      .has_prev_i ((k >= 2) ? 1'b1 : 1'b0),
      .flag_m1_i  (cols[k-1]),
      .flag_m2_i  (flag_m2),
      .prev_pat_i (prev_pat),
      .flag_o     (cols[k]),
      .pat_o      (pats[k]),
      .grow_o     (grows[k])
    );
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = matched_r;
  assign out_ch.status  = status_r;

endmodule
